// ----- rtl/vfr_pkg.sv -----
package vfr_pkg;

  // Point and key geometry
  localparam int unsigned COORD_W  = 18;
  localparam int unsigned KEY_W    = 3 * COORD_W;
  localparam int unsigned RANGE_W  = 17;
  localparam int unsigned INV_W    = 16;

  // Table entry tag: a slot counts as used only when its tag equals the current epoch
  localparam int unsigned TAG_W       = 8;
  localparam logic [TAG_W-1:0] EPOCH_CLEAR = '0;
  localparam logic [TAG_W-1:0] EPOCH_FIRST = TAG_W'(1);
  localparam logic [TAG_W-1:0] EPOCH_LAST  = '1;

  // Hash: 64-bit golden-ratio multiply, index taken from bit 40 upwards
  localparam int unsigned HASH_W      = 64;
  localparam int unsigned HASH_SHIFT  = 40;
  localparam int unsigned HIDX_W      = HASH_W - HASH_SHIFT;
  localparam int unsigned CHUNK_W     = 16;
  localparam int unsigned HASH_STEPS  = 9;
  localparam int unsigned STEP_W      = 4;
  localparam int unsigned SHIFT_W     = 6;
  localparam int unsigned PROD_W      = COORD_W + CHUNK_W;

  // Remainder unit: bits folded in per cycle
  localparam int unsigned MOD_BITS    = 4;
  localparam int unsigned MOD_CYCLES  = HIDX_W / MOD_BITS;
  localparam int unsigned MCNT_W      = 3;

  // Configuration register indices
  typedef enum logic [1:0] {
    CFG_MIN_RANGE = 2'd0,
    CFG_MAX_RANGE = 2'd1,
    CFG_VOXEL_EN  = 2'd2,
    CFG_INV_LEAF  = 2'd3
  } cfg_idx_e;

  // Key chunk (0 = z, 1 = y, 2 = x) used by each multiply-accumulate step
  function automatic logic [1:0] step_chunk(input logic [STEP_W-1:0] step);
    logic [1:0] sel;
    case (step)
      4'd0, 4'd1, 4'd2, 4'd3: sel = 2'd0;
      4'd4, 4'd5, 4'd6:       sel = 2'd1;
      default:                sel = 2'd2;
    endcase
    return sel;
  endfunction

  // 16-bit slice of the hash multiplier used by each step
  function automatic logic [CHUNK_W-1:0] step_mult(input logic [STEP_W-1:0] step);
    logic [CHUNK_W-1:0] m;
    case (step)
      4'd0, 4'd4, 4'd7: m = 16'h7C15;
      4'd1, 4'd5, 4'd8: m = 16'h7F4A;
      4'd2, 4'd6:       m = 16'h79B9;
      default:          m = 16'h9E37;
    endcase
    return m;
  endfunction

  // Left shift of each partial product inside the 64-bit accumulator
  function automatic logic [SHIFT_W-1:0] step_shift(input logic [STEP_W-1:0] step);
    logic [SHIFT_W-1:0] s;
    case (step)
      4'd0:    s = 6'd0;
      4'd1:    s = 6'd16;
      4'd2:    s = 6'd32;
      4'd3:    s = 6'd48;
      4'd4:    s = 6'd18;
      4'd5:    s = 6'd34;
      4'd6:    s = 6'd50;
      4'd7:    s = 6'd36;
      default: s = 6'd52;
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/vfr_key_ram.sv -----
module vfr_key_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 62
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/vfr_hash.sv -----
module vfr_hash
  import vfr_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [KEY_W-1:0]               key_i,
  output logic                           done_o,
  output logic [$clog2(TABLE_SLOTS)-1:0] slot_o
);

  localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned REM_W   = SLOT_W + 1;
  localparam bit          IS_POW2 = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;

  typedef enum logic [1:0] {
    H_IDLE,
    H_MAC,
    H_MOD
  } hash_state_e;

  hash_state_e          state_q, state_d;
  logic [STEP_W-1:0]    step_q, step_d;
  logic [MCNT_W-1:0]    mcnt_q, mcnt_d;
  logic [HASH_W-1:0]    acc_q, acc_d;
  logic [HIDX_W-1:0]    hidx_q, hidx_d;
  logic [REM_W-1:0]     rem_q, rem_d;
  logic                 done_q, done_d;
  logic [SLOT_W-1:0]    slot_q, slot_d;

  logic [COORD_W-1:0]   chunk;
  logic [PROD_W-1:0]    prod;
  logic [HASH_W-1:0]    acc_sum;
  logic [REM_W-1:0]     rem_step;

  // Select the key chunk and multiply it by one slice of the constant
  always_comb begin
    case (step_chunk(step_q))
      2'd0:    chunk = key_i[COORD_W-1:0];
      2'd1:    chunk = key_i[2*COORD_W-1:COORD_W];
      default: chunk = key_i[KEY_W-1:2*COORD_W];
    endcase
    prod    = PROD_W'(chunk) * PROD_W'(step_mult(step_q));
    acc_sum = acc_q + (HASH_W'(prod) << step_shift(step_q));
  end

  // Fold four index bits into the running remainder, most significant first
  always_comb begin
    rem_step = rem_q;
    for (int b = 0; b < MOD_BITS; b++) begin
      rem_step = {rem_step[REM_W-2:0], hidx_q[HIDX_W-1-b]};
      if (rem_step >= REM_W'(TABLE_SLOTS)) begin
        rem_step = rem_step - REM_W'(TABLE_SLOTS);
      end
    end
  end

  // Sequence: multiply-accumulate, then reduce modulo the table size
  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    mcnt_d  = mcnt_q;
    acc_d   = acc_q;
    hidx_d  = hidx_q;
    rem_d   = rem_q;
    done_d  = 1'b0;
    slot_d  = slot_q;
    case (state_q)
      H_IDLE: begin
        if (start_i) begin
          state_d = H_MAC;
          step_d  = '0;
          acc_d   = '0;
        end
      end
      H_MAC: begin
        acc_d  = acc_sum;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(HASH_STEPS - 1)) begin
          if (IS_POW2) begin
            slot_d  = acc_sum[HASH_SHIFT +: SLOT_W];
            done_d  = 1'b1;
            state_d = H_IDLE;
          end else begin
            hidx_d  = acc_sum[HASH_W-1:HASH_SHIFT];
            rem_d   = '0;
            mcnt_d  = '0;
            state_d = H_MOD;
          end
        end
      end
      H_MOD: begin
        rem_d  = rem_step;
        hidx_d = hidx_q << MOD_BITS;
        mcnt_d = mcnt_q + MCNT_W'(1);
        if (mcnt_q == MCNT_W'(MOD_CYCLES - 1)) begin
          slot_d  = rem_step[SLOT_W-1:0];
          done_d  = 1'b1;
          state_d = H_IDLE;
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      step_q  <= '0;
      mcnt_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      mcnt_q  <= mcnt_d;
      done_q  <= done_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    acc_q  <= acc_d;
    hidx_q <= hidx_d;
    rem_q  <= rem_d;
    slot_q <= slot_d;
  end

  assign done_o = done_q;
  assign slot_o = slot_q;

endmodule

// ----- rtl/voxel_first_point_range_filter_unit.sv -----
// Channel  Direction  Handshake                    Word
// ------   ---------  ---------------------------  -----------------------------------------
// in       input      in_valid_i / in_stall_o      pos_x/y/z, coord_valid, scan_start
// out      output     out_valid_o / out_stall_i    out_x/y/z, table_overflow
// cfg      input      cfg_valid_i / cfg_ready_o    cfg_index_i, cfg_data_i
//
// One point at a time. A point dropped by the range test passes the multiply and range
// states; a pass-through point also goes through the emit state. In voxel mode a point
// also runs the hash multiply-accumulate steps and its done flag, the remainder steps
// when TABLE_SLOTS is not a power of two, and a read then compare on the key memory
// read port for each probe; a point whose voxel is already stored skips the emit state.
// After reset, and on every 255th scan start, a clearing pass sweeps all TABLE_SLOTS
// slots of the key memory while in_stall_o stays high. A waiting output word does not
// stop the next point being taken; a point that finishes into a full output waits.
module voxel_first_point_range_filter_unit
  import vfr_pkg::*;
#(
  parameter int unsigned TABLE_SLOTS = 1024,
  parameter int unsigned MAX_PROBES  = 8
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // Point input
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] pos_x_i,
  input  logic signed [COORD_W-1:0] pos_y_i,
  input  logic signed [COORD_W-1:0] pos_z_i,
  input  logic                      coord_valid_i,
  input  logic                      scan_start_i,
  // Point output
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [COORD_W-1:0] out_x_o,
  output logic signed [COORD_W-1:0] out_y_o,
  output logic signed [COORD_W-1:0] out_z_o,
  output logic                      table_overflow_o,
  // Configuration writes
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [1:0]                cfg_index_i,
  input  logic [RANGE_W-1:0]        cfg_data_i
);

  localparam int unsigned SLOT_W  = $clog2(TABLE_SLOTS);
  localparam int unsigned PROBE_W = (MAX_PROBES > 1) ? $clog2(MAX_PROBES) : 1;
  localparam int unsigned ENTRY_W = TAG_W + KEY_W;
  localparam int unsigned SQ_W    = 2 * COORD_W - 1;
  localparam int unsigned D2_W    = 2 * COORD_W;
  localparam int unsigned RSQ_W   = 2 * RANGE_W;
  localparam int unsigned IXP_W   = COORD_W + INV_W + 1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL,
    S_RANGE,
    S_HASH,
    S_PROBE,
    S_CMP,
    S_EMIT
  } state_e;

  // Control state
  state_e               state_q, state_d;
  logic [TAG_W-1:0]     epoch_q, epoch_d;
  logic [SLOT_W-1:0]    clr_addr_q, clr_addr_d;
  logic                 clr_ret_q, clr_ret_d;
  logic [SLOT_W-1:0]    probe_addr_q, probe_addr_d;
  logic [PROBE_W-1:0]   probe_cnt_q, probe_cnt_d;
  logic                 ovf_q, ovf_d;
  logic                 out_valid_q, out_valid_d;

  // Configuration
  logic [RANGE_W-1:0]   min_range_q, min_range_d;
  logic [RANGE_W-1:0]   max_range_q, max_range_d;
  logic                 voxel_en_q, voxel_en_d;
  logic [INV_W-1:0]     inv_leaf_q, inv_leaf_d;
  logic [RSQ_W-1:0]     lo_sq_q, hi_sq_q;

  // Point payload and arithmetic
  logic signed [COORD_W-1:0] pos_x_q, pos_y_q, pos_z_q;
  logic                      coord_valid_q;
  logic [SQ_W-1:0]           sq_x_q, sq_y_q, sq_z_q;
  logic signed [IXP_W-1:0]   ixp_x_q, ixp_y_q, ixp_z_q;
  logic signed [D2_W-1:0]    sq_x_w, sq_y_w, sq_z_w;
  logic signed [IXP_W-1:0]   inv_s;
  logic [D2_W-1:0]           dist_sq;
  logic                      in_range;
  logic [KEY_W-1:0]          key;

  logic signed [COORD_W-1:0] out_x_q, out_y_q, out_z_q;
  logic                      out_ovf_q;

  // Handshake and memory signals
  logic                 in_take, out_free, out_load;
  logic                 hash_start, hash_done;
  logic [SLOT_W-1:0]    hash_slot;
  logic                 ram_rd_en, ram_wr_en;
  logic [SLOT_W-1:0]    ram_wr_addr;
  logic [ENTRY_W-1:0]   ram_wr_data, ram_rd_data;
  logic                 entry_used, entry_match;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_take     = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign cfg_ready_o = 1'b1;

  // Squares and voxel index products, one lane per axis
  assign inv_s  = IXP_W'($signed({1'b0, inv_leaf_q}));
  assign sq_x_w = D2_W'(pos_x_q) * D2_W'(pos_x_q);
  assign sq_y_w = D2_W'(pos_y_q) * D2_W'(pos_y_q);
  assign sq_z_w = D2_W'(pos_z_q) * D2_W'(pos_z_q);

  // Distance test, bounds inclusive
  assign dist_sq  = D2_W'(sq_x_q) + D2_W'(sq_y_q) + D2_W'(sq_z_q);
  assign in_range = (dist_sq >= D2_W'(lo_sq_q)) && (dist_sq <= D2_W'(hi_sq_q));

  // Floor division by 2^16 is an arithmetic shift; keep the low 18 bits per axis
  assign key = {ixp_x_q[16 +: COORD_W], ixp_y_q[16 +: COORD_W], ixp_z_q[16 +: COORD_W]};

  // Slot is live only when tagged with the current epoch
  assign entry_used  = (ram_rd_data[KEY_W +: TAG_W] == epoch_q);
  assign entry_match = (ram_rd_data[KEY_W-1:0] == key);

  vfr_hash #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hash_start),
    .key_i   (key),
    .done_o  (hash_done),
    .slot_o  (hash_slot)
  );

  vfr_key_ram #(
    .DEPTH (TABLE_SLOTS),
    .WIDTH (ENTRY_W)
  ) u_key_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ram_rd_en),
    .rd_addr_i (probe_addr_q),
    .rd_data_o (ram_rd_data),
    .wr_en_i   (ram_wr_en),
    .wr_addr_i (ram_wr_addr),
    .wr_data_i (ram_wr_data)
  );

  // Configuration writes
  always_comb begin
    min_range_d = min_range_q;
    max_range_d = max_range_q;
    voxel_en_d  = voxel_en_q;
    inv_leaf_d  = inv_leaf_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_RANGE: min_range_d = cfg_data_i;
        CFG_MAX_RANGE: max_range_d = cfg_data_i;
        CFG_VOXEL_EN:  voxel_en_d  = cfg_data_i[0];
        CFG_INV_LEAF:  inv_leaf_d  = cfg_data_i[INV_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer: clear, range test, hash, probe, record, emit
  always_comb begin
    state_d      = state_q;
    epoch_d      = epoch_q;
    clr_addr_d   = clr_addr_q;
    clr_ret_d    = clr_ret_q;
    probe_addr_d = probe_addr_q;
    probe_cnt_d  = probe_cnt_q;
    ovf_d        = ovf_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_load     = 1'b0;
    hash_start   = 1'b0;
    ram_rd_en    = 1'b0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = probe_addr_q;
    ram_wr_data  = {epoch_q, key};
    case (state_q)
      S_CLEAR: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = clr_addr_q;
        ram_wr_data = {EPOCH_CLEAR, {KEY_W{1'b0}}};
        clr_addr_d  = clr_addr_q + SLOT_W'(1);
        if (clr_addr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          clr_addr_d = '0;
          epoch_d    = EPOCH_FIRST;
          clr_ret_d  = 1'b0;
          state_d    = clr_ret_q ? S_MUL : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          state_d = S_MUL;
          // Retire the table by moving to a fresh epoch; sweep when the tags run out
          if (scan_start_i) begin
            if (epoch_q == EPOCH_LAST) begin
              clr_ret_d = 1'b1;
              state_d   = S_CLEAR;
            end else begin
              epoch_d = epoch_q + TAG_W'(1);
            end
          end
        end
      end
      S_MUL: state_d = S_RANGE;
      S_RANGE: begin
        if (!coord_valid_q || !in_range) begin
          state_d = S_IDLE;
        end else if (!voxel_en_q) begin
          ovf_d   = 1'b0;
          state_d = S_EMIT;
        end else begin
          hash_start = 1'b1;
          state_d    = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          probe_addr_d = hash_slot;
          probe_cnt_d  = '0;
          state_d      = S_PROBE;
        end
      end
      S_PROBE: begin
        ram_rd_en = 1'b1;
        state_d   = S_CMP;
      end
      S_CMP: begin
        if (entry_used) begin
          if (entry_match) begin
            // Voxel already seen: drop the point
            state_d = S_IDLE;
          end else if (probe_cnt_q == PROBE_W'(MAX_PROBES - 1)) begin
            ovf_d   = 1'b1;
            state_d = S_EMIT;
          end else begin
            probe_cnt_d  = probe_cnt_q + PROBE_W'(1);
            probe_addr_d = (probe_addr_q == SLOT_W'(TABLE_SLOTS - 1)) ?
                           '0 : probe_addr_q + SLOT_W'(1);
            state_d      = S_PROBE;
          end
        end else begin
          // Free slot: record the key and pass the point on
          ram_wr_en = 1'b1;
          ovf_d     = 1'b0;
          state_d   = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load    = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State, configuration and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      epoch_q      <= EPOCH_FIRST;
      clr_addr_q   <= '0;
      clr_ret_q    <= 1'b0;
      probe_addr_q <= '0;
      probe_cnt_q  <= '0;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      min_range_q  <= RANGE_W'(1000);
      max_range_q  <= RANGE_W'(100000);
      voxel_en_q   <= 1'b1;
      inv_leaf_q   <= INV_W'(655);
    end else begin
      state_q      <= state_d;
      epoch_q      <= epoch_d;
      clr_addr_q   <= clr_addr_d;
      clr_ret_q    <= clr_ret_d;
      probe_addr_q <= probe_addr_d;
      probe_cnt_q  <= probe_cnt_d;
      ovf_q        <= ovf_d;
      out_valid_q  <= out_valid_d;
      min_range_q  <= min_range_d;
      max_range_q  <= max_range_d;
      voxel_en_q   <= voxel_en_d;
      inv_leaf_q   <= inv_leaf_d;
    end
  end

  // Hold the point, square the bounds, register the products
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pos_x_q       <= pos_x_i;
      pos_y_q       <= pos_y_i;
      pos_z_q       <= pos_z_i;
      coord_valid_q <= coord_valid_i;
    end
    lo_sq_q <= RSQ_W'(min_range_q) * RSQ_W'(min_range_q);
    hi_sq_q <= RSQ_W'(max_range_q) * RSQ_W'(max_range_q);
    sq_x_q  <= sq_x_w[SQ_W-1:0];
    sq_y_q  <= sq_y_w[SQ_W-1:0];
    sq_z_q  <= sq_z_w[SQ_W-1:0];
    ixp_x_q <= IXP_W'(pos_x_q) * inv_s;
    ixp_y_q <= IXP_W'(pos_y_q) * inv_s;
    ixp_z_q <= IXP_W'(pos_z_q) * inv_s;
  end

  // Output word
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q   <= pos_x_q;
      out_y_q   <= pos_y_q;
      out_z_q   <= pos_z_q;
      out_ovf_q <= ovf_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_x_o          = out_x_q;
  assign out_y_o          = out_y_q;
  assign out_z_o          = out_z_q;
  assign table_overflow_o = out_ovf_q;

endmodule

// ----- tb/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import vfr_pkg::*;

  localparam int SLOTS         = 1024;
  localparam int PROBES        = 8;
  localparam int SETTLE_CYCLES = 64;
  localparam int N_PHASES      = 8;
  localparam int N_SCRIPT      = 21;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    bit     valid;
    bit     start;
  } point_t;

  typedef struct {
    coord_t x;
    coord_t y;
    coord_t z;
    bit     overflow;
  } kept_t;

  // One directed row: the point, and where it is obvious, whether it is kept
  typedef struct {
    int x;
    int y;
    int z;
    bit valid;
    bit start;
    bit typed;
    bit kept;
    bit ovf;
  } script_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic signed [COORD_W-1:0] pos_x_i;
  logic signed [COORD_W-1:0] pos_y_i;
  logic signed [COORD_W-1:0] pos_z_i;
  logic                 coord_valid_i;
  logic                 scan_start_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic signed [COORD_W-1:0] out_x_o;
  logic signed [COORD_W-1:0] out_y_o;
  logic signed [COORD_W-1:0] out_z_o;
  logic                 table_overflow_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [1:0]           cfg_index_i;
  logic [RANGE_W-1:0]   cfg_data_i;

  // Filter settings as the block should hold them
  bit [RANGE_W-1:0] lo_range_mm = 17'd1000;
  bit [RANGE_W-1:0] hi_range_mm = 17'd100000;
  bit               voxel_on    = 1'b1;
  bit [INV_W-1:0]   inv_leaf    = 16'd655;

  // Voxel occupancy as the block should hold it
  logic [KEY_W-1:0] key_store [SLOTS];
  bit               slot_taken [SLOTS];

  kept_t  due_points [$];
  point_t recent [$];

  bit idle_on = 1'b1;
  int faults;
  int words_checked;
  int overflows_seen;
  int points_sent;
  int starts_sent;
  int settings_used = 1;

  // x, y, z, valid, start, typed, kept, overflow
  script_row_t script [N_SCRIPT] = '{
    '{   2000,       0,       0, 1, 1, 1, 1, 0}, // first point of a fresh scan
    '{   2000,       0,       0, 1, 0, 1, 0, 0}, // same voxel again: drop
    '{    999,       0,       0, 1, 0, 1, 0, 0}, // just short of minimum range
    '{   1000,       0,       0, 1, 0, 1, 1, 0}, // minimum bound is inclusive
    '{ 100000,       0,       0, 1, 0, 1, 1, 0}, // maximum bound is inclusive
    '{ 100001,       0,       0, 1, 0, 1, 0, 0}, // just beyond maximum range
    '{      0,       0,       0, 1, 0, 1, 0, 0}, // origin
    '{   5000,       0,       0, 0, 0, 1, 0, 0}, // invalid coordinates
    '{-131072, -131072, -131072, 1, 0, 1, 0, 0}, // most negative corner
    '{ 131071,  131071,  131071, 1, 0, 1, 0, 0}, // most positive corner
    '{-131072,       0,       0, 1, 0, 1, 0, 0}, // most negative on one axis
    '{ -40000,   50000,  -60000, 1, 0, 0, 0, 0}, // mixed signs
    '{  -1000,       0,       0, 1, 0, 1, 1, 0}, // negative index rounds down
    '{   -990,     150,       0, 1, 0, 0, 0, 0},
    '{  -1000,       0,       0, 1, 0, 1, 0, 0}, // negative voxel seen before
    '{  70000,  -70000,       0, 0, 1, 1, 0, 0}, // scan start on a dropped point clears
    '{   2000,       0,       0, 1, 0, 1, 1, 0}, // kept again after the clear
    '{  -1000,       0,       0, 1, 0, 1, 1, 0},
    '{      0,    1000,       0, 1, 0, 0, 0, 0},
    '{      0,       0,   -1000, 1, 0, 0, 0, 0},
    '{  57735,   57735,   57735, 1, 0, 0, 0, 0}  // diagonal close to maximum range
  };

  voxel_first_point_range_filter_unit #(
    .TABLE_SLOTS(SLOTS),
    .MAX_PROBES (PROBES)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .pos_x_i         (pos_x_i),
    .pos_y_i         (pos_y_i),
    .pos_z_i         (pos_z_i),
    .coord_valid_i   (coord_valid_i),
    .scan_start_i    (scan_start_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_x_o         (out_x_o),
    .out_y_o         (out_y_o),
    .out_z_o         (out_z_o),
    .table_overflow_o(table_overflow_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void wipe_voxels();
    foreach (slot_taken[i]) slot_taken[i] = 1'b0;
  endfunction

  function automatic longint dist_sq(point_t p);
    longint xs, ys, zs;
    xs = p.x;
    ys = p.y;
    zs = p.z;
    return xs * xs + ys * ys + zs * zs;
  endfunction

  function automatic bit in_range(point_t p);
    longint d2, lo2, hi2;
    d2  = dist_sq(p);
    lo2 = longint'(lo_range_mm) * longint'(lo_range_mm);
    hi2 = longint'(hi_range_mm) * longint'(hi_range_mm);
    return (d2 >= lo2) && (d2 <= hi2);
  endfunction

  // floor(c * inv / 2^16): an arithmetic shift rounds towards minus infinity
  function automatic logic [COORD_W-1:0] voxel_axis(coord_t c);
    longint scaled;
    scaled = longint'(c) * longint'(inv_leaf);
    scaled = scaled >>> INV_W;
    return scaled[COORD_W-1:0];
  endfunction

  function automatic logic [KEY_W-1:0] voxel_key(point_t p);
    return {voxel_axis(p.x), voxel_axis(p.y), voxel_axis(p.z)};
  endfunction

  function automatic int hash_slot(logic [KEY_W-1:0] key);
    logic [HASH_W-1:0] mixed;
    mixed = HASH_W'(key);
    mixed = mixed * 64'h9E3779B97F4A7C15;
    return int'((mixed >> HASH_SHIFT) % SLOTS);
  endfunction

  // Work out whether a point leaves the block, and with which overflow flag
  function automatic bit filter_point(point_t p, output kept_t w);
    logic [KEY_W-1:0] key;
    int base, s, probe;
    bit placed;
    w.x        = p.x;
    w.y        = p.y;
    w.z        = p.z;
    w.overflow = 1'b0;
    if (p.start) wipe_voxels();
    if (!p.valid || !in_range(p)) return 1'b0;
    if (voxel_on) begin
      key    = voxel_key(p);
      base   = hash_slot(key);
      placed = 1'b0;
      for (probe = 0; probe < PROBES && !placed; probe++) begin
        s = (base + probe) % SLOTS;
        if (slot_taken[s]) begin
          if (key_store[s] == key) return 1'b0;
        end else begin
          slot_taken[s] = 1'b1;
          key_store[s]  = key;
          placed        = 1'b1;
        end
      end
      w.overflow = !placed;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------- point sources

  function automatic point_t wild_point();
    point_t p;
    p.x     = coord_t'($urandom());
    p.y     = coord_t'($urandom());
    p.z     = coord_t'($urandom());
    p.valid = 1'b1;
    p.start = 1'b0;
    return p;
  endfunction

  // Try for a point whose distance falls between the bounds, where the bounds allow one
  function automatic point_t ranged_point();
    point_t p;
    int r, q, tries;
    p = wild_point();
    if (lo_range_mm > hi_range_mm) return p;
    for (tries = 0; tries < 16; tries++) begin
      r   = $urandom_range(lo_range_mm, hi_range_mm);
      q   = r / 4;
      p.x = coord_t'($urandom_range(0, 2 * q) - q);
      p.y = coord_t'($urandom_range(0, 2 * q) - q);
      p.z = coord_t'($urandom_range(0, 2 * q) - q);
      case ($urandom_range(0, 2))
        0:       p.x = coord_t'($urandom_range(0, 1) ? r : -r);
        1:       p.y = coord_t'($urandom_range(0, 1) ? r : -r);
        default: p.z = coord_t'($urandom_range(0, 1) ? r : -r);
      endcase
      if (in_range(p)) return p;
    end
    return p;
  endfunction

  // Revisit a recent point with a nudge of at most one millimetre per axis
  function automatic point_t echo_point();
    point_t p;
    if (recent.size() == 0) return ranged_point();
    p     = recent[$urandom_range(0, recent.size() - 1)];
    p.x   = coord_t'(p.x + coord_t'($urandom_range(0, 2)) - 1);
    p.y   = coord_t'(p.y + coord_t'($urandom_range(0, 2)) - 1);
    p.z   = coord_t'(p.z + coord_t'($urandom_range(0, 2)) - 1);
    p.valid = 1'b1;
    p.start = 1'b0;
    return p;
  endfunction

  function automatic point_t next_point(bit every_scan);
    point_t p;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      p = ranged_point();
      recent = {recent, p};
      if (recent.size() > 8) void'(recent.pop_front());
    end else if (pick < 70) begin
      p = echo_point();
    end else if (pick < 85) begin
      p = wild_point();
    end else begin
      p       = wild_point();
      p.valid = 1'b0;
    end
    p.start = every_scan || ($urandom_range(0, 14) == 0);
    return p;
  endfunction

  // ---------------------------------------------------------------- drivers

  // Present one word, hold it until taken, then record what should come out
  task automatic offer_point(point_t p, bit typed, bit typed_kept, bit typed_ovf);
    kept_t w;
    bit kept;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk_i);
    end
    pos_x_i       = p.x;
    pos_y_i       = p.y;
    pos_z_i       = p.z;
    coord_valid_i = p.valid;
    scan_start_i  = p.start;
    in_valid_i    = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    kept = filter_point(p, w);
    if (typed) begin
      kept       = typed_kept;
      w.overflow = typed_ovf;
    end
    if (kept) due_points = {due_points, w};
    points_sent++;
    if (p.start) starts_sent++;
    @(negedge clk_i);
  endtask

  // Drain every pending word and wait until no point is left in flight
  task automatic settle();
    in_valid_i = 1'b0;
    while (due_points.size() != 0 || in_stall_o) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int value);
    cfg_index_i = idx;
    cfg_data_i  = RANGE_W'(value);
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_MIN_RANGE: lo_range_mm = RANGE_W'(value);
      CFG_MAX_RANGE: hi_range_mm = RANGE_W'(value);
      CFG_VOXEL_EN:  voxel_on    = value[0];
      default:       inv_leaf    = INV_W'(value);
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_filter(int lo, int hi, int en, int inv);
    write_reg(CFG_MIN_RANGE, lo);
    write_reg(CFG_MAX_RANGE, hi);
    write_reg(CFG_VOXEL_EN, en);
    write_reg(CFG_INV_LEAF, inv);
    cfg_valid_i = 1'b0;
    settings_used++;
  endtask

  // Find points whose voxels all hash to one slot and push them through,
  // so the probe window fills and the last new voxel overflows
  task automatic crowd_one_slot();
    point_t           found [$];
    logic [KEY_W-1:0] keys [$];
    point_t           p;
    logic [KEY_W-1:0] key;
    int target, tries;
    bit dup;
    p = ranged_point();
    found = {found, p};
    keys  = {keys, voxel_key(p)};
    target = hash_slot(keys[0]);
    for (tries = 0; tries < 200000 && found.size() <= PROBES; tries++) begin
      p   = ranged_point();
      key = voxel_key(p);
      if (in_range(p) && hash_slot(key) == target) begin
        dup = 1'b0;
        foreach (keys[i]) if (keys[i] == key) dup = 1'b1;
        if (!dup) begin
          found = {found, p};
          keys  = {keys, key};
        end
      end
    end
    foreach (found[i]) offer_point(found[i], 1'b0, 1'b0, 1'b0);
    // the overflowed voxel was never stored, the first one was
    offer_point(found[found.size() - 1], 1'b0, 1'b0, 1'b0);
    offer_point(found[0], 1'b0, 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic compare_field(string name, coord_t want, coord_t got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      faults++;
    end
  endtask

  task automatic check_word();
    kept_t w;
    if (due_points.size() == 0) begin
      $display("%0t: output word with none expected, got x=%0d y=%0d z=%0d overflow=%0b",
               $time, out_x_o, out_y_o, out_z_o, table_overflow_o);
      faults++;
      return;
    end
    w = due_points.pop_front();
    compare_field("out_x", w.x, out_x_o);
    compare_field("out_y", w.y, out_y_o);
    compare_field("out_z", w.z, out_z_o);
    compare_field("table_overflow", coord_t'(w.overflow), coord_t'({1'b0, table_overflow_o}));
    words_checked++;
    if (w.overflow) overflows_seen++;
  endtask

  // Sample output words at the rising edge, stall in random bursts
  initial begin
    int hold_left;
    hold_left   = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) check_word();
      @(negedge clk_i);
      if (hold_left > 0) begin
        hold_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        hold_left = $urandom_range(1, 16);
      end
      out_stall_i = (hold_left > 0);
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin
    point_t p;
    int phase, n, count;
    int lo, hi, en, inv;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    pos_x_i       = '0;
    pos_y_i       = '0;
    pos_z_i       = '0;
    coord_valid_i = 1'b0;
    scan_start_i  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = CFG_MIN_RANGE;
    cfg_data_i    = '0;
    wipe_voxels();
    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed points at the reset settings
    foreach (script[i]) begin
      p.x     = coord_t'(script[i].x);
      p.y     = coord_t'(script[i].y);
      p.z     = coord_t'(script[i].z);
      p.valid = script[i].valid;
      p.start = script[i].start;
      offer_point(p, script[i].typed, script[i].kept, script[i].ovf);
    end

    // Random points, one register setting per phase
    for (phase = 0; phase < N_PHASES; phase++) begin
      settle();
      case (phase)
        0: begin  // widest window, one millimetre leaves
          lo = 0; hi = 131071; en = 1; inv = 65535;
        end
        1: begin  // voxel bypass
          lo = $urandom_range(0, 5000); hi = $urandom_range(20000, 131071);
          en = 0; inv = $urandom_range(0, 65535);
        end
        2: begin  // zero reciprocal: one voxel for the whole scan
          lo = $urandom_range(0, 2000); hi = $urandom_range(50000, 131071);
          en = 1; inv = 0;
        end
        3: begin  // crossed bounds pass nothing
          lo = 131071; hi = 0; en = 1; inv = $urandom_range(1, 65535);
        end
        4: begin
          lo = $urandom_range(0, 3000); hi = $urandom_range(60000, 131071);
          en = 1; inv = $urandom_range(20000, 65535);
        end
        5: begin  // coarsest non-zero reciprocal
          lo = 0; hi = $urandom_range(1000, 131071); en = 1; inv = 1;
        end
        6: begin  // a scan start on every point, enough to wrap the table epoch
          lo = $urandom_range(0, 2000); hi = 131071; en = 1;
          inv = $urandom_range(1, 65535);
        end
        default: begin
          lo = $urandom_range(0, 10000); hi = $urandom_range(lo, 131071);
          en = $urandom_range(0, 1); inv = $urandom_range(1, 65535);
        end
      endcase
      program_filter(lo, hi, en, inv);
      idle_on = !(phase == 2 || phase == N_PHASES - 1);
      recent.delete();
      count = (phase == 6) ? 260 : 50;
      for (n = 0; n < count; n++) begin
        if ((phase == 0 || phase == 4) && (n == 10 || n == 30)) crowd_one_slot();
        offer_point(next_point(phase == 6), 1'b0, 1'b0, 1'b0);
      end
    end

    settle();
    $display("Sent %0d points with %0d scan starts over %0d register settings (bypass, crossed",
             points_sent, starts_sent, settings_used);
    $display("bounds, zero and full-scale reciprocals); checked %0d words, %0d with overflow.",
             words_checked, overflows_seen);
    if (faults == 0) begin
      $display("testbench passed");
    end else begin
      $display("%0d mismatches found", faults);
      $display("testbench failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("Timed out with %0d words still expected", due_points.size());
    $display("testbench failed");
    $finish;
  end

endmodule
